### rtl/cdeq_pkg.sv
package cdeq_pkg;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    KIND_PUSH_REAR  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

### rtl/cdeq_ctrl.sv
module cdeq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdeq_pkg::cmd_t cmd_o
);
  import cdeq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_RESP;
        end
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/cdeq_dp.sv
module cdeq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdeq_pkg::cmd_t                cmd_i,
  input  cdeq_pkg::kind_e               kind_i,
  input  logic [cdeq_pkg::WORD_W-1:0]   push_value_i,
  output logic [cdeq_pkg::WORD_W-1:0]   pop_value_o,
  output cdeq_pkg::status_e             status_o,
  output logic                          is_empty_o,
  output logic                          is_full_o
);
  import cdeq_pkg::*;

  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] head_nxt, head_prv, tail_nxt, tail_prv, addr;
  logic             we, re;
  status_e          status_d, status_q;
  logic [WORD_W-1:0] rd_q;
  logic             pop_ok_q, empty_q, full_q;

  assign head_nxt = (head_q == IdxLast) ? '0 : head_q + 1'b1;
  assign head_prv = (head_q == '0) ? IdxLast : head_q - 1'b1;
  assign tail_nxt = (tail_q == IdxLast) ? '0 : tail_q + 1'b1;
  assign tail_prv = (tail_q == '0) ? IdxLast : tail_q - 1'b1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    addr     = head_q;
    we       = 1'b0;
    re       = 1'b0;
    status_d = ST_DONE;
    unique case (kind_i)
      KIND_PUSH_REAR, KIND_PUSH_FRONT: begin
        if (cnt_q == CntFull) begin
          status_d = ST_FULL;
        end else begin
          we    = cmd_i.exec;
          cnt_d = cnt_q + 1'b1;
          if (kind_i == KIND_PUSH_REAR) begin
            addr   = tail_q;
            tail_d = tail_nxt;
          end else begin
            addr   = head_prv;
            head_d = head_prv;
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          re    = cmd_i.exec;
          cnt_d = cnt_q - 1'b1;
          if (kind_i == KIND_POP_FRONT) begin
            addr   = head_q;
            head_d = head_nxt;
          end else begin
            addr   = tail_prv;
            tail_d = tail_prv;
          end
        end
      end
      default: status_d = ST_DONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= push_value_i;
    end
    if (re) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= re;
      empty_q  <= (cnt_d == '0);
      full_q   <= (cnt_d == CntFull);
    end
  end

  assign pop_value_o = pop_ok_q ? rd_q : '0;
  assign status_o    = status_q;
  assign is_empty_o  = empty_q;
  assign is_full_o   = full_q;

endmodule

### rtl/circular_double_ended_queue.sv
// Double-ended queue of DEPTH (128) signed 32-bit words in a circular store.
// tuser selects push rear, push front, pop front or pop rear; every accepted
// transaction returns one result with the popped word (zero unless a pop
// succeeded), a status (done, push rejected full, pop rejected empty) and the
// empty/full flags after the request. One request is in flight at a time:
// the request is executed in the accept cycle (one access to the single-port
// store plus the pointer update) and its result is offered the next cycle. The
// next request is accepted only after the result transaction completes.
module circular_double_ended_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cdeq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [31:0] push_value
  input  logic [1:0]                          s_axis_tuser,   // [1:0] kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cdeq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // [31:0] pop_value,
                                                              // [33:32] status,
                                                              // [34] is_empty,
                                                              // [35] is_full,
                                                              // [39:36] zero
);
  import cdeq_pkg::*;

  cmd_t              cmd;
  logic [WORD_W-1:0] pop_value;
  status_e           status;
  logic              is_empty, is_full;

  cdeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  cdeq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_e'(s_axis_tuser)),
    .push_value_i (s_axis_tdata),
    .pop_value_o  (pop_value),
    .status_o     (status),
    .is_empty_o   (is_empty),
    .is_full_o    (is_full)
  );

  assign m_axis_tdata = {4'b0000, is_full, is_empty, status, pop_value};

endmodule

### rtl/cdeq_chk.sv
module cdeq_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [cdeq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import cdeq_pkg::*;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no result after accepted transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!(m_axis_tdata[34] && m_axis_tdata[35])
                       && (m_axis_tdata[33:32] != 2'd3)))
    else $error("inconsistent status or flags");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[33:32] != ST_DONE)) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("rejected request returned nonzero word");

endmodule

bind circular_double_ended_queue cdeq_chk u_cdeq_chk (.*);

### tb/sv/tb_circular_double_ended_queue.sv
module tb_circular_double_ended_queue;
  import cdeq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] pop_value;
    status_e     status;
    logic        is_empty;
    logic        is_full;
  } deque_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] push_value
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] pop_value, [33:32] status,
                                     // [34] is_empty, [35] is_full

  logic [31:0]   mirror_slots [DEPTH];
  int unsigned   mirror_head  = 0;
  int unsigned   mirror_tail  = 0;
  int unsigned   mirror_count = 0;
  deque_result_t pending_results [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_cycles  = 0;
  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;

  circular_double_ended_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // deque behavior applied at each accepted request
  task automatic predict_request(kind_e req_kind, logic [31:0] word);
    deque_result_t res;
    res.pop_value = '0;
    res.status    = ST_DONE;
    case (req_kind)
      KIND_PUSH_REAR: begin
        if (mirror_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          mirror_slots[mirror_tail] = word;
          mirror_tail = (mirror_tail + 1) % DEPTH;
          mirror_count++;
        end
      end
      KIND_PUSH_FRONT: begin
        if (mirror_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_slots[mirror_head] = word;
          mirror_count++;
        end
      end
      KIND_POP_FRONT: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_value = mirror_slots[mirror_head];
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_count--;
        end
      end
      default: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          mirror_tail = (mirror_tail + DEPTH - 1) % DEPTH;
          res.pop_value = mirror_slots[mirror_tail];
          mirror_count--;
        end
      end
    endcase
    res.is_empty = (mirror_count == 0);
    res.is_full  = (mirror_count >= DEPTH);
    pending_results.push_back(res);
  endtask

  // called at a rising edge; leaves tvalid high after acceptance
  task automatic send_request(kind_e req_kind, logic [31:0] word);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= req_kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(req_kind, word);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic kind_e random_kind(int unsigned push_pct);
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
    end
    return $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
  endfunction

  // result sink: random ready, long hold-off on request, field compare
  initial begin
    deque_result_t exp_res;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result tdata %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.pop_value) begin
            $display("%0t: pop_value expected %h actual %h", $time,
                     exp_res.pop_value, m_axis_tdata[31:0]);
            error_count++;
          end
          if (m_axis_tdata[33:32] !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, m_axis_tdata[33:32]);
            error_count++;
          end
          if (m_axis_tdata[34] !== exp_res.is_empty) begin
            $display("%0t: is_empty expected %b actual %b", $time,
                     exp_res.is_empty, m_axis_tdata[34]);
            error_count++;
          end
          if (m_axis_tdata[35] !== exp_res.is_full) begin
            $display("%0t: is_full expected %b actual %b", $time,
                     exp_res.is_full, m_axis_tdata[35]);
            error_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic test_directed();
    src_idle_pct = 10;
    snk_idle_pct = 60;
    send_request(KIND_POP_FRONT, 32'hffff_ffff);
    send_request(KIND_POP_REAR, 32'h8000_0000);
    send_request(KIND_PUSH_FRONT, 32'h8000_0000);
    send_request(KIND_PUSH_REAR, 32'h7fff_ffff);
    send_request(KIND_PUSH_FRONT, 32'hffff_ffff);
    send_request(KIND_PUSH_REAR, 32'h0000_0000);
    send_request(KIND_POP_FRONT, 32'h1234_5678);
    send_request(KIND_POP_REAR, 32'hdead_beef);
    send_request(KIND_POP_FRONT, 32'h0000_0000);
    send_request(KIND_POP_FRONT, 32'hffff_ffff);
    send_request(KIND_POP_REAR, 32'h0000_0000);
    send_request(KIND_PUSH_REAR, 32'h5555_5555);
    send_request(KIND_PUSH_REAR, 32'haaaa_aaaa);
    send_request(KIND_POP_REAR, 32'h0);
    send_request(KIND_POP_REAR, 32'h0);
    send_request(KIND_PUSH_FRONT, 32'h0000_0001);
    send_request(KIND_POP_REAR, 32'h0);
    send_request(KIND_PUSH_REAR, 32'hfeed_0001);
    send_request(KIND_POP_FRONT, 32'h0);
    wait_drained();
  endtask

  // fill to full from both ends, reject pushes, drain, reject pops
  task automatic test_full_and_empty();
    while (mirror_count < DEPTH - 1) begin
      send_request($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR, random_word());
    end
    send_request(KIND_PUSH_FRONT, random_word());
    send_request(KIND_PUSH_REAR, random_word());
    send_request(KIND_PUSH_FRONT, random_word());
    while (mirror_count > 0) begin
      send_request($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_REAR, random_word());
    end
    send_request(KIND_POP_FRONT, random_word());
    send_request(KIND_POP_REAR, random_word());
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_cycles  = 300;
    repeat (40) send_request(random_kind(70), random_word());
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_items, int unsigned src_pct,
                             int unsigned snk_pct);
    int unsigned sent;
    int unsigned burst;
    int unsigned push_pct;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(60, 5);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (burst) begin
        send_request(random_kind(push_pct), random_word());
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_full_and_empty();
    test_backpressure();
    test_random(600, 10, 60);
    test_random(600, 60, 10);
    test_random(500, 0, 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/cdeq_pkg.sv
rtl/cdeq_ctrl.sv
rtl/cdeq_dp.sv
rtl/circular_double_ended_queue.sv
rtl/cdeq_chk.sv
tb/sv/tb_circular_double_ended_queue.sv
